// ===== src/printable_vigenere_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// printable_vigenere_cipher_assert.svh
// Assertion macros used by the checker file pvc_checker.
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_VIGENERE_CIPHER_ASSERT_SVH
`define PRINTABLE_VIGENERE_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PVC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pvc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PVC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pvc assertion failed");

`endif

// ===== src/pvc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, constants and helpers for the printable Vigenere cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvc_pkg;

	localparam int CHAR_W     = 21;
	localparam int PICK_W     = 3;
	localparam int MAX_KEY    = 16;
	localparam int POS_W      = 4;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [CHAR_W-1:0] PRINT_LO = 21'd32;
	localparam logic [CHAR_W-1:0] PRINT_HI = 21'd126;
	localparam logic [CHAR_W-1:0] TAB_CHAR = 21'd9;

	localparam logic [CHAR_W-1:0] MARK_0 = 21'd182;
	localparam logic [CHAR_W-1:0] MARK_1 = 21'd164;
	localparam logic [CHAR_W-1:0] MARK_2 = 21'd161;
	localparam logic [CHAR_W-1:0] MARK_3 = 21'd167;
	localparam logic [CHAR_W-1:0] MARK_4 = 21'd191;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 8'd3;

	localparam logic [63:0]      KEY_LOW_RST  = 64'h0000_0000_7966_616D;
	localparam logic [63:0]      KEY_HIGH_RST = 64'h0;
	localparam logic [LEN_W-1:0] KEY_LEN_RST  = 5'd4;

	typedef struct packed {
		logic [63:0]      key_high;
		logic [63:0]      key_low;
		logic [LEN_W-1:0] key_len;
		logic             decrypt;
	} cfg_t;

	// Tab replacement; picks above four take the last code
	function automatic logic [CHAR_W-1:0] marker_code(input logic [PICK_W-1:0] pick);
		logic [CHAR_W-1:0] code;
		case (pick)
			3'd0:    code = MARK_0;
			3'd1:    code = MARK_1;
			3'd2:    code = MARK_2;
			3'd3:    code = MARK_3;
			default: code = MARK_4;
		endcase
		return code;
	endfunction

endpackage

// ===== src/pvc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pvc_cfg_regs
// Configuration register file: key bytes, key length, direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [pvc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [pvc_pkg::CFG_DATA_W-1:0]    wr_data,
	output pvc_pkg::cfg_t                     cfg
);

	pvc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low  <= pvc_pkg::KEY_LOW_RST;
			cfg_q.key_high <= pvc_pkg::KEY_HIGH_RST;
			cfg_q.key_len  <= pvc_pkg::KEY_LEN_RST;
			cfg_q.decrypt  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				pvc_pkg::REG_KEY_LOW:  cfg_q.key_low  <= wr_data;
				pvc_pkg::REG_KEY_HIGH: cfg_q.key_high <= wr_data;
				pvc_pkg::REG_KEY_LEN:  cfg_q.key_len  <= wr_data[pvc_pkg::LEN_W-1:0];
				pvc_pkg::REG_DECRYPT:  cfg_q.decrypt  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/pvc_core.sv =====
// ----------------------------------------------------------------------------
// pvc_core
// Per-character transform and key position step, purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvc_core (
	input  pvc_pkg::cfg_t                     cfg,
	input  logic [pvc_pkg::POS_W-1:0]         key_pos,
	input  logic                              rewind,
	input  logic [pvc_pkg::CHAR_W-1:0]        char_in,
	input  logic [pvc_pkg::PICK_W-1:0]        pick,
	output logic [pvc_pkg::CHAR_W-1:0]        char_out,
	output logic                              used,
	output logic [pvc_pkg::POS_W-1:0]         key_pos_next
);

	logic [pvc_pkg::LEN_W-1:0] len_eff;
	logic [pvc_pkg::POS_W-1:0] pos_start;
	logic [pvc_pkg::POS_W-1:0] pos;
	logic [pvc_pkg::LEN_W-1:0] pos_inc;
	logic [127:0]              key_vec;
	logic [7:0]                kbyte;
	logic [7:0]                k_mod;
	logic [7:0]                s_raw;
	logic [7:0]                shift;
	logic [6:0]                d;
	logic [7:0]                sum;
	logic [7:0]                sum_mod;
	logic                      printable;

	always_comb begin
		// zero length acts as one, anything past the table as the full table
		if (cfg.key_len == '0)
			len_eff = 5'd1;
		else if (cfg.key_len > 5'(pvc_pkg::MAX_KEY))
			len_eff = 5'(pvc_pkg::MAX_KEY);
		else
			len_eff = cfg.key_len;
	end

	assign pos_start = rewind ? '0 : key_pos;
	assign pos       = ({1'b0, pos_start} < len_eff) ? pos_start : '0;
	assign pos_inc   = {1'b0, pos} + 5'd1;

	assign key_vec = {cfg.key_high, cfg.key_low};
	assign kbyte   = key_vec[{pos, 3'b000} +: 8];

	// shift = ((k mod 95) + 64) mod 95, each step a compare and subtract
	always_comb begin
		if (kbyte >= 8'd190)
			k_mod = kbyte - 8'd190;
		else if (kbyte >= 8'd95)
			k_mod = kbyte - 8'd95;
		else
			k_mod = kbyte;
		s_raw = k_mod + 8'd64;
		shift = (s_raw >= 8'd95) ? s_raw - 8'd95 : s_raw;
	end

	assign printable = char_in inside {[pvc_pkg::PRINT_LO:pvc_pkg::PRINT_HI]};
	assign d         = char_in[6:0] - 7'd32;

	always_comb begin
		if (cfg.decrypt)
			sum = {1'b0, d} + 8'd95 - shift;
		else
			sum = {1'b0, d} + shift;
		sum_mod = (sum >= 8'd95) ? sum - 8'd95 : sum;
	end

	always_comb begin
		char_out     = char_in;
		used         = 1'b0;
		key_pos_next = pos_start;
		if (printable) begin
			char_out     = pvc_pkg::CHAR_W'(sum_mod + 8'd32);
			used         = 1'b1;
			key_pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[pvc_pkg::POS_W-1:0];
		end else if (cfg.decrypt) begin
			if (char_in inside {pvc_pkg::MARK_0, pvc_pkg::MARK_1, pvc_pkg::MARK_2,
					pvc_pkg::MARK_3, pvc_pkg::MARK_4})
				char_out = pvc_pkg::TAB_CHAR;
		end else if (char_in == pvc_pkg::TAB_CHAR) begin
			char_out = pvc_pkg::marker_code(pick);
		end
	end

endmodule

// ===== src/printable_vigenere_cipher.sv =====
// ----------------------------------------------------------------------------
// printable_vigenere_cipher
// Vigenere cipher over printable ASCII on a stream of code points.
// ----------------------------------------------------------------------------
// One character in, one character out. Each item passes through the input
// register and then the result register; throughput is one character per
// cycle while out_stall does not hold a result. The key position register is
// updated as the item leaves the input stage, which is what lets the next
// character follow directly. Printable characters (32..126) are shifted mod 95
// by the current key byte and advance the key position; tabs become marker
// codes when encrypting, marker codes become tabs when decrypting. Write the
// configuration registers only while the stream is idle.
`timescale 1ns / 1ps

module printable_vigenere_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pvc_pkg::CHAR_W-1:0]        in_char,
	input  logic [pvc_pkg::PICK_W-1:0]        tab_pick,
	input  logic                              start_of_text,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pvc_pkg::CHAR_W-1:0]        out_char,
	output logic                              key_used,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pvc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pvc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pvc_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic [pvc_pkg::CHAR_W-1:0]    char_s1;
	logic [pvc_pkg::PICK_W-1:0]    pick_s1;
	logic                          rewind_s1;
	logic [pvc_pkg::POS_W-1:0]     key_pos_q;
	logic                          out_valid_q;
	logic [pvc_pkg::CHAR_W-1:0]    out_char_q;
	logic                          key_used_q;

	logic                          res_free;
	logic                          move_s1;
	logic                          load_s1;
	logic [pvc_pkg::CHAR_W-1:0]    res_char;
	logic                          res_used;
	logic [pvc_pkg::POS_W-1:0]     key_pos_next;

	assign cfg_ready = 1'b1;

	pvc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pvc_core u_core (
		.cfg          (cfg),
		.key_pos      (key_pos_q),
		.rewind       (rewind_s1),
		.char_in      (char_s1),
		.pick         (pick_s1),
		.char_out     (res_char),
		.used         (res_used),
		.key_pos_next (key_pos_next)
	);

	// result register is free when empty or its transfer happens now
	assign res_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			key_pos_q   <= '0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (move_s1)
				valid_s1 <= 1'b0;
			if (move_s1) begin
				out_valid_q <= 1'b1;
				key_pos_q   <= key_pos_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1   <= in_char;
			pick_s1   <= tab_pick;
			rewind_s1 <= start_of_text;
		end
		if (move_s1) begin
			out_char_q <= res_char;
			key_used_q <= res_used;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign key_used  = key_used_q;

endmodule

// ===== src/pvc_checker.sv =====
// ----------------------------------------------------------------------------
// pvc_checker
// Port-level checks for printable_vigenere_cipher, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "printable_vigenere_cipher_assert.svh"

module pvc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [pvc_pkg::CHAR_W-1:0]        in_char,
	input logic [pvc_pkg::PICK_W-1:0]        tab_pick,
	input logic                              start_of_text,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [pvc_pkg::CHAR_W-1:0]        out_char,
	input logic                              key_used,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [pvc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [pvc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic out_printable;

	assign out_printable = (out_char >= pvc_pkg::PRINT_LO) && (out_char <= pvc_pkg::PRINT_HI);

	// a stalled result holds
	`PVC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_char) && $stable(key_used))

	// a shifted character always lands back in the printable range
	`PVC_ASSERT_NOW(a_used_printable, out_valid && key_used, out_printable)

	// non-printable input never maps to a printable output
	`PVC_ASSERT_NOW(a_unused_nonprint, out_valid && !key_used, !out_printable)

endmodule

bind printable_vigenere_cipher pvc_checker u_pvc_checker (.*);
